// File: rtl/ppt_pkg.sv
package ppt_pkg;

  // default fraction width of all fixed-point values
  localparam int PPT_FRAC_BITS_DEF = 16;

  // quotient bits per lane, one division cell each
  localparam int QBITS = 32;

  // configuration register indexes
  localparam logic [2:0] CFG_X_GAIN  = 3'd0;
  localparam logic [2:0] CFG_Y_GAIN  = 3'd1;
  localparam logic [2:0] CFG_W_GAIN  = 3'd2;
  localparam logic [2:0] CFG_X_OFS   = 3'd3;
  localparam logic [2:0] CFG_Y_OFS   = 3'd4;
  localparam logic [2:0] CFG_W_OFS   = 3'd5;
  localparam logic [2:0] CFG_TRANSP  = 3'd6;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } ppt_in_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               zero_weight;
    logic               saturated;
  } ppt_out_t;

  // per-item control traveling with the division chain
  typedef struct packed {
    logic valid;
    logic zero;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } ppt_ctl_t;

endpackage

// File: rtl/projective_point_transform.sv
// Channel   | Ports                           | Transfer
// ----------+---------------------------------+------------------------------
// input     | start, busy, in_data            | edge with start & !busy
// result    | out_valid, out_data             | edge ending the strobe cycle
// config    | cfg_we, cfg_index, cfg_wdata    | edge with cfg_we
//
// One point enters per cycle; busy stays low, so points may come back to back.
// Pipeline: 4 front stages (input, six 32x32 multipliers, sums, magnitudes),
// then one division cell per quotient bit (32), then the output register.
// Reset clears the valid chain and loads the identity matrix.
// The receiver cannot stall; each result strobes for exactly one cycle.
module projective_point_transform import ppt_pkg::*; #(
  parameter int FRAC_BITS = PPT_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  ppt_in_t     in_data,
  output logic        out_valid,
  output ppt_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int SW  = 66 - FRAC_BITS;
  localparam int AW  = SW + 32;
  localparam int LAT = 4 + QBITS + 1;

  logic [63:0] x_gain_r, y_gain_r, w_gain_r;
  logic [31:0] x_ofs_r, y_ofs_r, w_ofs_r;
  logic        transp_r;

  ppt_ctl_t      ctl [QBITS+1];
  logic [AW-1:0] rx [QBITS+1];
  logic [AW-1:0] ry [QBITS+1];
  logic [AW-1:0] dv [QBITS+1];
  logic [31:0]   qx [QBITS+1];
  logic [31:0]   qy [QBITS+1];

  logic        out_valid_r;
  ppt_out_t    out_r, out_nxt;
  logic [32:0] limx, limy, magx, magy;
  logic        satx, saty;

  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_gain_r <= 64'(64'd1 << FRAC_BITS);
      y_gain_r <= 64'(64'd1 << FRAC_BITS) << 32;
      w_gain_r <= '0;
      x_ofs_r  <= '0;
      y_ofs_r  <= '0;
      w_ofs_r  <= 32'(64'd1 << FRAC_BITS);
      transp_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_GAIN: x_gain_r <= cfg_wdata;
        CFG_Y_GAIN: y_gain_r <= cfg_wdata;
        CFG_W_GAIN: w_gain_r <= cfg_wdata;
        CFG_X_OFS:  x_ofs_r  <= cfg_wdata[31:0];
        CFG_Y_OFS:  y_ofs_r  <= cfg_wdata[31:0];
        CFG_W_OFS:  w_ofs_r  <= cfg_wdata[31:0];
        CFG_TRANSP: transp_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  ppt_front #(.FRAC_BITS(FRAC_BITS), .SW(SW), .AW(AW)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (start & ~busy),
    .pt     (in_data),
    .x_gain (x_gain_r),
    .y_gain (y_gain_r),
    .w_gain (w_gain_r),
    .x_ofs  (x_ofs_r),
    .y_ofs  (y_ofs_r),
    .w_ofs  (w_ofs_r),
    .transp (transp_r),
    .ctl_o  (ctl[0]),
    .rx_o   (rx[0]),
    .ry_o   (ry[0]),
    .d_o    (dv[0])
  );

  assign qx[0] = '0;
  assign qy[0] = '0;

  // row of division cells, most significant quotient bit first
  for (genvar i = 0; i < QBITS; i++) begin : g_cell
    ppt_div_cell #(.AW(AW), .BIT(QBITS-1-i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl[i]),
      .rx_i  (rx[i]),
      .ry_i  (ry[i]),
      .d_i   (dv[i]),
      .qx_i  (qx[i]),
      .qy_i  (qy[i]),
      .ctl_o (ctl[i+1]),
      .rx_o  (rx[i+1]),
      .ry_o  (ry[i+1]),
      .d_o   (dv[i+1]),
      .qx_o  (qx[i+1]),
      .qy_o  (qy[i+1])
    );
  end

  // saturation, sign and zero-weight handling
  always_comb begin
    limx = ctl[QBITS].neg_x ? 33'h080000000 : 33'h07fffffff;
    limy = ctl[QBITS].neg_y ? 33'h080000000 : 33'h07fffffff;
    satx = ctl[QBITS].ovf_x || ({1'b0, qx[QBITS]} > limx);
    saty = ctl[QBITS].ovf_y || ({1'b0, qy[QBITS]} > limy);
    magx = satx ? limx : {1'b0, qx[QBITS]};
    magy = saty ? limy : {1'b0, qy[QBITS]};
    out_nxt.x = ctl[QBITS].neg_x ? 32'(-magx) : magx[31:0];
    out_nxt.y = ctl[QBITS].neg_y ? 32'(-magy) : magy[31:0];
    out_nxt.zero_weight = ctl[QBITS].zero;
    out_nxt.saturated   = satx | saty;
    if (ctl[QBITS].zero) begin
      out_nxt.x         = '0;
      out_nxt.y         = '0;
      out_nxt.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl[QBITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a result only follows a transfer in at the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without matching transfer in");

  // zero weight gives zero coordinates and no clipping
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.zero_weight) |->
      (out_data.x == '0 && out_data.y == '0 && !out_data.saturated))
    else $error("zero weight result not cleared");

  // clipping leaves at least one coordinate at a range limit
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |->
      (out_data.x == 32'sh7fffffff || out_data.x == 32'sh80000000 ||
       out_data.y == 32'sh7fffffff || out_data.y == 32'sh80000000))
    else $error("saturated flag without clipped value");

endmodule

// File: rtl/ppt_div_cell.sv
module ppt_div_cell import ppt_pkg::*; #(
  parameter int AW  = 82,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ppt_ctl_t      ctl_i,
  input  logic [AW-1:0] rx_i,
  input  logic [AW-1:0] ry_i,
  input  logic [AW-1:0] d_i,
  input  logic [31:0]   qx_i,
  input  logic [31:0]   qy_i,
  output ppt_ctl_t      ctl_o,
  output logic [AW-1:0] rx_o,
  output logic [AW-1:0] ry_o,
  output logic [AW-1:0] d_o,
  output logic [31:0]   qx_o,
  output logic [31:0]   qy_o
);

  ppt_ctl_t      ctl_r;
  logic [AW-1:0] rx_r, rx_nxt, ry_r, ry_nxt, d_r, dk;
  logic [31:0]   qx_r, qx_nxt, qy_r, qy_nxt;

  // one restoring step on both lanes: try subtracting divisor at this weight
  always_comb begin
    dk     = d_i << BIT;
    rx_nxt = rx_i;
    ry_nxt = ry_i;
    qx_nxt = qx_i;
    qy_nxt = qy_i;
    if (rx_i >= dk) begin
      rx_nxt      = rx_i - dk;
      qx_nxt[BIT] = 1'b1;
    end
    if (ry_i >= dk) begin
      ry_nxt      = ry_i - dk;
      qy_nxt[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    rx_r <= rx_nxt;
    ry_r <= ry_nxt;
    d_r  <= d_i;
    qx_r <= qx_nxt;
    qy_r <= qy_nxt;
  end

  assign ctl_o = ctl_r;
  assign rx_o  = rx_r;
  assign ry_o  = ry_r;
  assign d_o   = d_r;
  assign qx_o  = qx_r;
  assign qy_o  = qy_r;

endmodule

// File: rtl/ppt_front.sv
module ppt_front import ppt_pkg::*; #(
  parameter int FRAC_BITS = PPT_FRAC_BITS_DEF,
  parameter int SW        = 66 - FRAC_BITS,
  parameter int AW        = SW + 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  ppt_in_t       pt,
  input  logic [63:0]   x_gain,
  input  logic [63:0]   y_gain,
  input  logic [63:0]   w_gain,
  input  logic [31:0]   x_ofs,
  input  logic [31:0]   y_ofs,
  input  logic [31:0]   w_ofs,
  input  logic          transp,
  output ppt_ctl_t      ctl_o,
  output logic [AW-1:0] rx_o,
  output logic [AW-1:0] ry_o,
  output logic [AW-1:0] d_o
);

  logic v1_r, v2_r, v3_r;
  ppt_in_t pt_r;

  // coefficient selection
  logic signed [31:0] cx0, cx1, cx2, cy0, cy1, cy2, cw0, cw1, cw2;
  logic signed [63:0] px0_r, px1_r, py0_r, py1_r, pw0_r, pw1_r;
  logic signed [31:0] cx_r, cy_r, cw_r;

  logic signed [SW-1:0] xs_nxt, ys_nxt, ws_nxt, xs_r, ys_r, ws_r;
  logic [SW-1:0]        mx, my, mw;
  logic [AW-1:0]        nx, ny, dd, dtop;
  ppt_ctl_t             ctl_nxt, ctl_r;
  logic [AW-1:0]        rx_r, ry_r, d_r;

  function automatic logic signed [SW-1:0] dot_sum(
    input logic signed [63:0] p1,
    input logic signed [63:0] p2,
    input logic signed [31:0] c
  );
    logic signed [64:0] s;
    logic signed [64:0] t;
    s = {p1[63], p1} + {p2[63], p2};
    t = s >>> FRAC_BITS;
    return SW'(t) + {{(SW-32){c[31]}}, c};
  endfunction

  always_comb begin
    cx0 = x_gain[31:0];
    cy1 = y_gain[63:32];
    cw2 = w_ofs;
    if (transp) begin
      cx1 = y_gain[31:0];   cx2 = w_gain[31:0];
      cy0 = x_gain[63:32];  cy2 = w_gain[63:32];
      cw0 = x_ofs;          cw1 = y_ofs;
    end else begin
      cx1 = x_gain[63:32];  cx2 = x_ofs;
      cy0 = y_gain[31:0];   cy2 = y_ofs;
      cw0 = w_gain[31:0];   cw1 = w_gain[63:32];
    end
  end

  // stage sums, magnitudes, sign, zero-weight and overflow tests
  always_comb begin
    xs_nxt = dot_sum(px0_r, px1_r, cx_r);
    ys_nxt = dot_sum(py0_r, py1_r, cy_r);
    ws_nxt = dot_sum(pw0_r, pw1_r, cw_r);
    mx   = xs_r[SW-1] ? SW'(-xs_r) : SW'(xs_r);
    my   = ys_r[SW-1] ? SW'(-ys_r) : SW'(ys_r);
    mw   = ws_r[SW-1] ? SW'(-ws_r) : SW'(ws_r);
    nx   = AW'(mx) << FRAC_BITS;
    ny   = AW'(my) << FRAC_BITS;
    dd   = AW'(mw);
    dtop = dd << QBITS;
    ctl_nxt.valid = v3_r;
    ctl_nxt.zero  = (ws_r == '0);
    ctl_nxt.neg_x = xs_r[SW-1] ^ ws_r[SW-1];
    ctl_nxt.neg_y = ys_r[SW-1] ^ ws_r[SW-1];
    ctl_nxt.ovf_x = (nx >= dtop);
    ctl_nxt.ovf_y = (ny >= dtop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      ctl_r <= '0;
    end else begin
      v1_r  <= take;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      ctl_r <= ctl_nxt;
    end
  end

  // payload: input, products, sums, divider operands
  always_ff @(posedge clk) begin
    pt_r  <= pt;
    px0_r <= 64'(pt_r.x) * 64'(cx0);
    px1_r <= 64'(pt_r.y) * 64'(cx1);
    py0_r <= 64'(pt_r.x) * 64'(cy0);
    py1_r <= 64'(pt_r.y) * 64'(cy1);
    pw0_r <= 64'(pt_r.x) * 64'(cw0);
    pw1_r <= 64'(pt_r.y) * 64'(cw1);
    cx_r  <= cx2;
    cy_r  <= cy2;
    cw_r  <= cw2;
    xs_r  <= xs_nxt;
    ys_r  <= ys_nxt;
    ws_r  <= ws_nxt;
    rx_r  <= nx;
    ry_r  <= ny;
    d_r   <= dd;
  end

  assign ctl_o = ctl_r;
  assign rx_o  = rx_r;
  assign ry_o  = ry_r;
  assign d_o   = d_r;

endmodule
